### rtl/tooiq_pkg.sv
package tooiq_pkg;

	localparam int MAX_INTERVALS = 16;
	localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

	// one table entry: [lo, hi) with merged flags
	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
		logic [7:0]  flg;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	typedef enum logic [0:0] {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	// how the copy pass rewrites the table
	typedef enum logic [2:0] {
		MD_DEQ,
		MD_APPEND,
		MD_MODIFY,
		MD_EXTEND,
		MD_INSERT
	} mode_t;

	// a before b, modulo 2^32
	function automatic logic seq_lt(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic logic seq_le(input logic [31:0] a, input logic [31:0] b);
		return !seq_lt(b, a);
	endfunction

endpackage

### rtl/tooiq_ram.sv
module tooiq_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/tcp_out_of_order_interval_queue_top.sv
// The table holds at most 16 stored intervals. Throughput: one item at a time; busy stays high
// until done, while the single read port walks the table once to scan (enqueue only) and once
// to rewrite it into the other bank; an enqueue dropped as full skips the rewrite.
// Reset clears the interval count and the control state; the table memories are not cleared.
// The result is shown on done for exactly one cycle; the receiver cannot stall.
module tcp_out_of_order_interval_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [31:0] seq,
	input  logic [15:0] length,
	input  logic [7:0]  seg_flags,
	input  logic [31:0] next_expected,
	output logic        done,
	output logic [31:0] result_seq,
	output logic [7:0]  out_flags,
	output logic        found,
	output logic        overflow
);
	import tooiq_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_COPY   = 6'b001000,
		ST_FLUSH  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t            state_q;
	logic              bank_q;
	logic [CNT_W-1:0]  cnt_q, rd_ptr_q, wp_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              cmd_q;
	logic [31:0]       seq_q, end_q, nxt_q;
	logic [7:0]        flg_q;
	mode_t             mode_q;
	logic [IDX_W-1:0]  tgt_q;
	logic              ii_found_q, ic_found_q;
	logic [IDX_W-1:0]  ii_idx_q, ic_idx_q;
	logic [31:0]       ic_hi_q;
	ent_t              last_q, h_q;
	logic              hv_q, ha_q, done_q;
	logic [31:0]       res_seq_q;
	logic [7:0]        res_flags_q;
	logic              res_found_q, res_ovf_q;

	ent_t              rd0, rd1, x, wdata_c, h_d, hcur, seg_e;
	logic              we_c, hv_d, ha_d, done_d, issue;
	logic              res_found_d;
	logic [31:0]       res_seq_d;
	logic [7:0]        res_flags_d;
	logic              start_abs, ins_here;
	logic [31:0]       mod_hi;

	assign busy       = (state_q != ST_IDLE);
	assign done       = (state_q == ST_DONE);
	assign result_seq = res_seq_q;
	assign out_flags  = res_flags_q;
	assign found      = res_found_q;
	assign overflow   = res_ovf_q;

	assign issue = ((state_q == ST_SCAN) || (state_q == ST_COPY)) && (rd_ptr_q < cnt_q);
	assign x     = bank_q ? rd1 : rd0;
	assign seg_e = '{lo: seq_q, hi: end_q, flg: flg_q};

	// ping-pong table banks: read the current one, rebuild into the other
	tooiq_ram #(.W(ENT_W), .D(MAX_INTERVALS)) u_bank0 (
		.clk   (clk),
		.we    (we_c && bank_q),
		.waddr (wp_q[IDX_W-1:0]),
		.wdata (wdata_c),
		.raddr (rd_ptr_q[IDX_W-1:0]),
		.rdata (rd0)
	);

	tooiq_ram #(.W(ENT_W), .D(MAX_INTERVALS)) u_bank1 (
		.clk   (clk),
		.we    (we_c && !bank_q),
		.waddr (wp_q[IDX_W-1:0]),
		.wdata (wdata_c),
		.raddr (rd_ptr_q[IDX_W-1:0]),
		.rdata (rd1)
	);

	// rewrite up to one entry per cycle during the copy pass; at the end flush the held entry or the appended segment
	always_comb begin
		we_c        = 1'b0;
		wdata_c     = x;
		h_d         = h_q;
		hv_d        = hv_q;
		ha_d        = ha_q;
		done_d      = done_q;
		res_seq_d   = res_seq_q;
		res_flags_d = res_flags_q;
		res_found_d = res_found_q;
		start_abs   = (mode_q == MD_EXTEND) && (idx_s1 == tgt_q);
		ins_here    = (mode_q == MD_INSERT) && ii_found_q && (idx_s1 == tgt_q);
		hcur        = ins_here ? seg_e : h_q;
		mod_hi      = seq_lt(x.hi, end_q) ? end_q : x.hi;
		if ((state_q == ST_COPY) && vld_s1) begin
			case (mode_q)
				MD_DEQ: begin
					if (done_q) begin
						we_c = 1'b1;
					end else if (seq_lt(nxt_q, x.lo)) begin
						done_d = 1'b1;
						we_c   = 1'b1;
					end else if (seq_le(nxt_q, x.hi)) begin
						done_d      = 1'b1;
						res_seq_d   = x.hi;
						res_flags_d = x.flg;
						res_found_d = 1'b1;
					end
				end
				MD_MODIFY: begin
					we_c = 1'b1;
					if (idx_s1 == tgt_q) begin
						wdata_c = '{lo: x.lo, hi: mod_hi, flg: x.flg | flg_q};
					end
				end
				MD_EXTEND, MD_INSERT: begin
					if (start_abs) begin
						h_d  = '{lo: x.lo, hi: end_q, flg: x.flg | flg_q};
						hv_d = 1'b1;
						ha_d = 1'b1;
					end else if (ins_here || (hv_q && ha_q)) begin
						if (seq_lt(hcur.hi, x.lo)) begin
							we_c    = 1'b1;
							wdata_c = hcur;
							h_d     = x;
							hv_d    = 1'b1;
							ha_d    = 1'b0;
						end else if (seq_le(hcur.hi, x.hi)) begin
							we_c    = 1'b1;
							wdata_c = '{lo: hcur.lo, hi: x.hi, flg: hcur.flg | x.flg};
							hv_d    = 1'b0;
							ha_d    = 1'b0;
						end else begin
							h_d  = hcur;
							hv_d = 1'b1;
							ha_d = 1'b1;
						end
					end else if (hv_q) begin
						we_c    = 1'b1;
						wdata_c = h_q;
						h_d     = x;
					end else begin
						we_c = 1'b1;
					end
				end
				default: begin
					we_c = 1'b1;
				end
			endcase
		end else if (state_q == ST_FLUSH) begin
			if (hv_q) begin
				we_c    = 1'b1;
				wdata_c = h_q;
			end else if ((mode_q == MD_APPEND) || ((mode_q == MD_INSERT) && !ii_found_q)) begin
				we_c    = 1'b1;
				wdata_c = seg_e;
			end
		end
	end

	// sequencer, scan bookkeeping and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bank_q   <= 1'b0;
			cnt_q    <= '0;
			rd_ptr_q <= '0;
			wp_q     <= '0;
			vld_s1   <= 1'b0;
			hv_q     <= 1'b0;
			ha_q     <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			vld_s1   <= issue;
			idx_s1   <= rd_ptr_q[IDX_W-1:0];
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q       <= cmd;
						seq_q       <= seq;
						end_q       <= seq + {16'd0, length};
						flg_q       <= seg_flags;
						nxt_q       <= next_expected;
						rd_ptr_q    <= '0;
						wp_q        <= '0;
						hv_q        <= 1'b0;
						ha_q        <= 1'b0;
						done_q      <= 1'b0;
						ic_found_q  <= 1'b0;
						ii_found_q  <= 1'b0;
						res_seq_q   <= (cmd == CMD_DEQ) ? next_expected : seq;
						res_flags_q <= '0;
						res_found_q <= 1'b0;
						res_ovf_q   <= 1'b0;
						mode_q      <= MD_DEQ;
						state_q     <= (cmd == CMD_DEQ) ? ST_COPY : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (vld_s1) begin
						if (!ic_found_q && seq_le(x.lo, seq_q) && seq_le(seq_q, x.hi)) begin
							ic_found_q <= 1'b1;
							ic_idx_q   <= idx_s1;
							ic_hi_q    <= x.hi;
						end
						if (!ii_found_q && seq_lt(seq_q, x.lo)) begin
							ii_found_q <= 1'b1;
							ii_idx_q   <= idx_s1;
						end
						if ({1'b0, idx_s1} == CNT_W'(cnt_q - 1'b1)) begin
							last_q <= x;
						end
					end
					if ((rd_ptr_q == cnt_q) && !vld_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					rd_ptr_q <= '0;
					state_q  <= ST_COPY;
					if (cnt_q == '0) begin
						mode_q <= MD_APPEND;
					end else if (seq_le(last_q.lo, seq_q) && seq_le(seq_q, last_q.hi)) begin
						mode_q    <= MD_MODIFY;
						tgt_q     <= IDX_W'(cnt_q - 1'b1);
						res_seq_q <= last_q.hi;
					end else if (seq_lt(last_q.hi, seq_q)) begin
						mode_q <= MD_APPEND;
						if (cnt_q == CNT_W'(MAX_INTERVALS)) begin
							res_ovf_q <= 1'b1;
							state_q   <= ST_DONE;
						end
					end else if (ic_found_q) begin
						tgt_q <= ic_idx_q;
						if (seq_le(end_q, ic_hi_q)) begin
							mode_q    <= MD_MODIFY;
							res_seq_q <= end_q;
						end else begin
							mode_q    <= MD_EXTEND;
							res_seq_q <= ic_hi_q;
						end
					end else begin
						mode_q <= MD_INSERT;
						tgt_q  <= ii_idx_q;
						if (cnt_q == CNT_W'(MAX_INTERVALS)) begin
							res_ovf_q <= 1'b1;
							state_q   <= ST_DONE;
						end
					end
				end
				ST_COPY: begin
					h_q         <= h_d;
					hv_q        <= hv_d;
					ha_q        <= ha_d;
					done_q      <= done_d;
					res_seq_q   <= res_seq_d;
					res_flags_q <= res_flags_d;
					res_found_q <= res_found_d;
					if (we_c) begin
						wp_q <= wp_q + 1'b1;
					end
					if ((rd_ptr_q == cnt_q) && !vld_s1) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					cnt_q   <= wp_q + CNT_W'(we_c);
					bank_q  <= !bank_q;
					hv_q    <= 1'b0;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_INTERVALS))
		else $error("interval count above table depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (cnt_q == CNT_W'(MAX_INTERVALS)) && (cmd_q == CMD_ENQ))
		else $error("overflow reported with room in the table");

	a_found_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (cmd_q == CMD_DEQ) && !overflow)
		else $error("found reported on an enqueue");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		we_c |-> (wp_q < CNT_W'(MAX_INTERVALS)))
		else $error("table rewrite past its depth");

	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |=> (bank_q != $past(bank_q)))
		else $error("bank not swapped after rewrite");

endmodule

### bench/tooiq_checker.sv
`timescale 1ns / 100ps

module tooiq_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        cmd,
	input  logic [31:0] seq,
	input  logic [15:0] length,
	input  logic [7:0]  seg_flags,
	input  logic [31:0] next_expected,
	input  logic        done,
	input  logic [31:0] result_seq,
	input  logic [7:0]  out_flags,
	input  logic        found,
	input  logic        overflow,
	output int          fail_count,
	output int          pending
);
	import tooiq_pkg::*;

	typedef struct {
		logic [31:0] rseq;
		logic [7:0]  flg;
		logic        fnd;
		logic        ovf;
	} reply_t;

	// shadow interval table
	logic [31:0] iv_lo [$];
	logic [31:0] iv_hi [$];
	logic [7:0]  iv_flg [$];
	reply_t      replies_due [$];

	function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function automatic logic not_after(input logic [31:0] a, input logic [31:0] b);
		return !is_before(b, a);
	endfunction

	// let entry i swallow the entries it reaches
	task automatic coalesce(input int i);
		while (i + 1 < iv_lo.size()) begin
			if (is_before(iv_hi[i], iv_lo[i+1])) break;
			if (not_after(iv_hi[i], iv_hi[i+1])) begin
				iv_lo[i+1] = iv_lo[i];
				iv_flg[i+1] |= iv_flg[i];
				iv_lo.delete(i); iv_hi.delete(i); iv_flg.delete(i);
				break;
			end
			iv_lo.delete(i+1); iv_hi.delete(i+1); iv_flg.delete(i+1);
		end
	endtask

	task automatic add_segment(input logic [31:0] s, input logic [31:0] e, input logic [7:0] f,
			output reply_t r);
		int n, last, i;
		logic [31:0] old;
		r = '{s, 8'h0, 1'b0, 1'b0};
		n = iv_lo.size();
		if (n == 0) begin
			iv_lo.push_back(s); iv_hi.push_back(e); iv_flg.push_back(f);
			return;
		end
		last = n - 1;
		if (not_after(iv_lo[last], s) && not_after(s, iv_hi[last])) begin
			r.rseq = iv_hi[last];
			if (is_before(iv_hi[last], e)) iv_hi[last] = e;
			iv_flg[last] |= f;
			return;
		end
		if (is_before(iv_hi[last], s)) begin
			if (n >= MAX_INTERVALS) r.ovf = 1'b1;
			else begin
				iv_lo.push_back(s); iv_hi.push_back(e); iv_flg.push_back(f);
			end
			return;
		end
		for (i = 0; i < n; i++) begin
			if (not_after(iv_lo[i], s) && not_after(s, iv_hi[i])) begin
				iv_flg[i] |= f;
				if (not_after(e, iv_hi[i])) begin
					r.rseq = e;
					return;
				end
				old = iv_hi[i];
				iv_hi[i] = e;
				coalesce(i);
				r.rseq = old;
				return;
			end
		end
		if (n >= MAX_INTERVALS) begin
			r.ovf = 1'b1;
			return;
		end
		for (i = 0; i < n; i++)
			if (is_before(s, iv_lo[i])) break;
		iv_lo.insert(i, s); iv_hi.insert(i, e); iv_flg.insert(i, f);
		coalesce(i);
	endtask

	task automatic take_in_order(input logic [31:0] nxt, output reply_t r);
		r = '{nxt, 8'h0, 1'b0, 1'b0};
		while (iv_lo.size() > 0) begin
			if (is_before(nxt, iv_lo[0])) break;
			if (not_after(nxt, iv_hi[0])) begin
				r.rseq = iv_hi[0];
				r.flg = iv_flg[0];
				r.fnd = 1'b1;
				iv_lo.delete(0); iv_hi.delete(0); iv_flg.delete(0);
				break;
			end
			iv_lo.delete(0); iv_hi.delete(0); iv_flg.delete(0);
		end
	endtask

	// predict on accept, compare on done
	always @(posedge clk or negedge arst_n) begin
		reply_t r, want;
		if (!arst_n) begin
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					$error("unexpected result seq=%h", result_seq);
					fail_count <= fail_count + 1;
				end else begin
					want = replies_due.pop_front();
					if (result_seq !== want.rseq || out_flags !== want.flg ||
							found !== want.fnd || overflow !== want.ovf)
						fail_count <= fail_count + 1;
					if (result_seq !== want.rseq)
						$error("result_seq expected %h got %h", want.rseq, result_seq);
					if (out_flags !== want.flg)
						$error("out_flags expected %h got %h", want.flg, out_flags);
					if (found !== want.fnd)
						$error("found expected %b got %b", want.fnd, found);
					if (overflow !== want.ovf)
						$error("overflow expected %b got %b", want.ovf, overflow);
				end
			end
			if (start && !busy) begin
				if (cmd == CMD_ENQ) add_segment(seq, seq + {16'h0, length}, seg_flags, r);
				else take_in_order(next_expected, r);
				replies_due.push_back(r);
			end
			pending <= replies_due.size();
		end
	end

endmodule

### bench/tb_tcp_out_of_order_interval_queue_top.sv
`timescale 1ns / 100ps

module tb_tcp_out_of_order_interval_queue_top;
	import tooiq_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        cmd;
	logic [31:0] seq;
	logic [15:0] length;
	logic [7:0]  seg_flags;
	logic [31:0] next_expected;
	logic        done;
	logic [31:0] result_seq;
	logic [7:0]  out_flags;
	logic        found;
	logic        overflow;
	int          fail_count;
	int          pending;

	// receive window state for well-formed traffic
	logic [31:0] rcv_next;

	tcp_out_of_order_interval_queue_top dut (.*);

	tooiq_checker u_checker (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// hold one item until accepted
	task automatic send_item(input cmd_t c, input logic [31:0] s, input logic [15:0] len,
			input logic [7:0] f, input logic [31:0] nxt, input bit calm);
		if (!calm)
			while ($urandom_range(99) < 23) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start <= 1'b1;
		cmd <= c;
		seq <= s;
		length <= len;
		seg_flags <= f;
		next_expected <= nxt;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic enq(input logic [31:0] s, input logic [15:0] len, input logic [7:0] f,
			input bit calm);
		send_item(CMD_ENQ, s, len, f, $urandom, calm);
	endtask

	task automatic deq(input logic [31:0] nxt, input bit calm);
		send_item(CMD_DEQ, $urandom, 16'($urandom), 8'($urandom), nxt, calm);
	endtask

	initial begin
		int k, w;
		logic [31:0] base;
		start = 1'b0; cmd = CMD_ENQ; seq = '0; length = '0; seg_flags = '0;
		next_expected = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, wrap, containment, extension
		deq(32'h0, 0);
		enq(32'hFFFF_FFF0, 16'hFFFF, 8'hFF, 0);
		enq(32'hFFFF_FFF8, 16'h4, 8'h01, 0);
		enq(32'h0000_0010, 16'h0, 8'h00, 0);
		enq(32'h0001_0000, 16'h10, 8'h80, 0);
		enq(32'h0000_FFE0, 16'h40, 8'h02, 0);
		deq(32'hFFFF_FFF0, 0);
		deq(32'hFFFF_FFFF, 0);
		// fill the table, then overflow at the tail and in a gap
		for (k = 0; k < 17; k++) enq(32'h1000 + k * 32'h100, 16'h10, 8'h1 << (k % 8), 0);
		enq(32'h1000 + 32'h2000, 16'h5, 8'h40, 0);
		enq(32'h1050, 16'h5, 8'h20, 0);
		enq(32'h1008, 16'h300, 8'h10, 0);
		deq(32'h1000 + 32'h800, 0);
		deq(32'h8000_0000, 0);

		// random: mostly in-window segments around a moving receive point
		rcv_next = $urandom;
		for (k = 0; k < 1820; k++) begin
			bit calm;
			calm = (k >= 600 && k < 800);
			w = $urandom_range(99);
			if (w < 5) enq($urandom, 16'($urandom), 8'($urandom), calm);
			else if (w < 8) deq($urandom, calm);
			else if (w < 70) begin
				base = rcv_next + $urandom_range(3000) - 200;
				enq(base, ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(300)),
					8'($urandom), calm);
			end else begin
				deq(rcv_next + $urandom_range(400) - 100, calm);
				rcv_next = rcv_next + $urandom_range(600);
			end
		end
		start <= 1'b0;

		while (pending > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
rtl/tooiq_pkg.sv
rtl/tooiq_ram.sv
rtl/tcp_out_of_order_interval_queue_top.sv
bench/tooiq_checker.sv
bench/tb_tcp_out_of_order_interval_queue_top.sv
